>>> rtl/euler_to_quaternion_assert.svh
// assertion macros for the euler to quaternion converter
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH
`ifndef SYNTHESIS
`define E2Q_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define E2Q_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define E2Q_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`define E2Q_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

>>> rtl/e2q_pkg.sv
// shared types, constants and tables of the euler to quaternion converter
package e2q_pkg;

  localparam int CORDIC_STEPS   = 30;
  localparam int CORDIC_W       = 32;
  localparam int CORDIC_FRAC    = 30;
  localparam int COMBINE_STAGES = 5;
  localparam int PIPE_DEPTH     = CORDIC_STEPS + 1 + COMBINE_STAGES;

  typedef logic signed [CORDIC_W-1:0] cordic_word_t;
  typedef logic [2:0] order_t;
  typedef logic [3:0] sign_sel_t;

  localparam cordic_word_t CORDIC_GAIN = 32'sd652032874;

  localparam order_t ORDER_XYZ = 3'd0;
  localparam order_t ORDER_YXZ = 3'd1;
  localparam order_t ORDER_ZXY = 3'd2;
  localparam order_t ORDER_ZYX = 3'd3;
  localparam order_t ORDER_YZX = 3'd4;
  localparam order_t ORDER_XZY = 3'd5;

  function automatic cordic_word_t cordic_atan(input int step);
    cordic_word_t a;
    unique case (step)
      0:  a = 32'sh20000000;
      1:  a = 32'sh12E4051E;
      2:  a = 32'sh09FB385B;
      3:  a = 32'sh051111D4;
      4:  a = 32'sh028B0D43;
      5:  a = 32'sh0145D7E1;
      6:  a = 32'sh00A2F61E;
      7:  a = 32'sh00517C55;
      8:  a = 32'sh0028BE53;
      9:  a = 32'sh00145F2F;
      10: a = 32'sh000A2F98;
      11: a = 32'sh000517CC;
      12: a = 32'sh00028BE6;
      13: a = 32'sh000145F3;
      14: a = 32'sh0000A2FA;
      15: a = 32'sh0000517D;
      16: a = 32'sh000028BE;
      17: a = 32'sh0000145F;
      18: a = 32'sh00000A30;
      19: a = 32'sh00000518;
      20: a = 32'sh0000028C;
      21: a = 32'sh00000146;
      22: a = 32'sh000000A3;
      23: a = 32'sh00000051;
      24: a = 32'sh00000029;
      25: a = 32'sh00000014;
      26: a = 32'sh0000000A;
      27: a = 32'sh00000005;
      28: a = 32'sh00000003;
      29: a = 32'sh00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

  // bit 0 x, bit 1 y, bit 2 z, bit 3 w; set means subtract
  function automatic sign_sel_t order_signs(input order_t ord);
    sign_sel_t s;
    unique case (ord)
      ORDER_XYZ: s = 4'b1010;
      ORDER_YXZ: s = 4'b0110;
      ORDER_ZXY: s = 4'b1001;
      ORDER_ZYX: s = 4'b0101;
      ORDER_YZX: s = 4'b1100;
      ORDER_XZY: s = 4'b0011;
      default:   s = 4'b1010;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/e2q_cordic.sv
// pipelined cordic giving sine and cosine of half an angle, one step per stage
module e2q_cordic import e2q_pkg::*; #(
  parameter int FRACTION_BITS = 14
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [15:0]              angle,
  output logic signed [FRACTION_BITS+1:0] half_sin,
  output logic signed [FRACTION_BITS+1:0] half_cos
);

  localparam int SH = CORDIC_FRAC - FRACTION_BITS;
  localparam longint HALF_L = (longint'(1) << SH) >> 1;
  localparam cordic_word_t HALF = cordic_word_t'(HALF_L);
  localparam cordic_word_t ONE = cordic_word_t'(longint'(1) << FRACTION_BITS);

  cordic_word_t x_r [CORDIC_STEPS];
  cordic_word_t y_r [CORDIC_STEPS];
  cordic_word_t z_r [CORDIC_STEPS];
  cordic_word_t x_nxt [CORDIC_STEPS];
  cordic_word_t y_nxt [CORDIC_STEPS];
  cordic_word_t z_nxt [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam cordic_word_t ATAN_I = cordic_atan(i);
    cordic_word_t x_in, y_in, z_in;
    logic         pos;
    if (i == 0) begin : g_first
      assign x_in = CORDIC_GAIN;
      assign y_in = '0;
      assign z_in = {angle[15], angle, 15'b0};
    end else begin : g_rest
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign z_in = z_r[i-1];
    end
    // a residual of zero rotates the positive way
    assign pos = !z_in[CORDIC_W-1];
    assign x_nxt[i] = pos ? x_in - (y_in >>> i) : x_in + (y_in >>> i);
    assign y_nxt[i] = pos ? y_in + (x_in >>> i) : y_in - (x_in >>> i);
    assign z_nxt[i] = pos ? z_in - ATAN_I : z_in + ATAN_I;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        x_r[i] <= x_nxt[i];
        y_r[i] <= y_nxt[i];
        z_r[i] <= z_nxt[i];
      end
    end
  end

  cordic_word_t cos_rnd, sin_rnd, cos_sat, sin_sat;
  logic signed [FRACTION_BITS+1:0] cos_r, sin_r;

  always_comb begin
    cos_rnd = (x_r[CORDIC_STEPS-1] + HALF) >>> SH;
    sin_rnd = (y_r[CORDIC_STEPS-1] + HALF) >>> SH;
    if (cos_rnd > ONE) begin
      cos_sat = ONE;
    end else if (cos_rnd < -ONE) begin
      cos_sat = -ONE;
    end else begin
      cos_sat = cos_rnd;
    end
    if (sin_rnd > ONE) begin
      sin_sat = ONE;
    end else if (sin_rnd < -ONE) begin
      sin_sat = -ONE;
    end else begin
      sin_sat = sin_rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_sat[FRACTION_BITS+1:0];
      sin_r <= sin_sat[FRACTION_BITS+1:0];
    end
  end

  assign half_sin = sin_r;
  assign half_cos = cos_r;

endmodule

>>> rtl/e2q_combine.sv
// product and sum stages forming the four quaternion components
module e2q_combine import e2q_pkg::*; #(
  parameter int FRACTION_BITS = 14
) (
  input  logic                            clk,
  input  logic                            en,
  input  sign_sel_t                       signs,
  input  logic signed [FRACTION_BITS+1:0] s1,
  input  logic signed [FRACTION_BITS+1:0] c1,
  input  logic signed [FRACTION_BITS+1:0] s2,
  input  logic signed [FRACTION_BITS+1:0] c2,
  input  logic signed [FRACTION_BITS+1:0] s3,
  input  logic signed [FRACTION_BITS+1:0] c3,
  output logic signed [15:0]              quat_x,
  output logic signed [15:0]              quat_y,
  output logic signed [15:0]              quat_z,
  output logic signed [15:0]              quat_w
);

  localparam int PW = FRACTION_BITS + 2;
  localparam int MW = 2 * PW;

  typedef logic signed [PW-1:0] fac_t;
  typedef logic signed [MW-1:0] prod_t;

  localparam prod_t HALF = prod_t'(longint'(1) << (FRACTION_BITS - 1));
  localparam prod_t ONE  = prod_t'(longint'(1) << FRACTION_BITS);

  prod_t sc_p_r, cs_p_r, cc_p_r, ss_p_r;
  fac_t  s3_d1_r, c3_d1_r, s3_d2_r, c3_d2_r;
  fac_t  sc_r, cs_r, cc_r, ss_r;
  prod_t t1_r [4];
  prod_t t2_r [4];
  prod_t sum_r [4];
  prod_t rnd [4];
  prod_t sat [4];
  logic signed [15:0] q_r [4];

  // pair products of the first two angles
  always_ff @(posedge clk) begin
    if (en) begin
      sc_p_r  <= s1 * c2;
      cs_p_r  <= c1 * s2;
      cc_p_r  <= c1 * c2;
      ss_p_r  <= s1 * s2;
      s3_d1_r <= s3;
      c3_d1_r <= c3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_r    <= fac_t'((sc_p_r + HALF) >>> FRACTION_BITS);
      cs_r    <= fac_t'((cs_p_r + HALF) >>> FRACTION_BITS);
      cc_r    <= fac_t'((cc_p_r + HALF) >>> FRACTION_BITS);
      ss_r    <= fac_t'((ss_p_r + HALF) >>> FRACTION_BITS);
      s3_d2_r <= s3_d1_r;
      c3_d2_r <= c3_d1_r;
    end
  end

  // products with the third angle, lane order x y z w
  always_ff @(posedge clk) begin
    if (en) begin
      t1_r[0] <= sc_r * c3_d2_r;
      t2_r[0] <= cs_r * s3_d2_r;
      t1_r[1] <= cs_r * c3_d2_r;
      t2_r[1] <= sc_r * s3_d2_r;
      t1_r[2] <= cc_r * s3_d2_r;
      t2_r[2] <= ss_r * c3_d2_r;
      t1_r[3] <= cc_r * c3_d2_r;
      t2_r[3] <= ss_r * s3_d2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        sum_r[k] <= signs[k] ? t1_r[k] - t2_r[k] : t1_r[k] + t2_r[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rnd[k] = (sum_r[k] + HALF) >>> FRACTION_BITS;
      if (rnd[k] > ONE) begin
        sat[k] = ONE;
      end else if (rnd[k] < -ONE) begin
        sat[k] = -ONE;
      end else begin
        sat[k] = rnd[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        q_r[k] <= sat[k][15:0];
      end
    end
  end

  assign quat_x = q_r[0];
  assign quat_y = q_r[1];
  assign quat_z = q_r[2];
  assign quat_w = q_r[3];

endmodule

>>> rtl/euler_to_quaternion.sv
// top level of the euler angles to unit quaternion converter
// pipeline from item accept to out_valid: 30 cordic steps, 1 round register, 5 combine stages
// throughput: one item per cycle; a one-entry skid register holds a stalled result
// the whole pipeline stalls only while the skid register is full
// reset clears valid bits, skid register and rotation order (XYZ); payload is not reset
`include "euler_to_quaternion_assert.svh"
module euler_to_quaternion import e2q_pkg::*; #(
  parameter int FRACTION_BITS = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_angle_x,
  input  logic signed [15:0] in_angle_y,
  input  logic signed [15:0] in_angle_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_quat_x,
  output logic signed [15:0] out_quat_y,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_w,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_rotation_order
);

  order_t                  order_r;
  logic [PIPE_DEPTH-1:0]   vld_r;
  logic                    adv;
  logic                    skid_v_r, skid_v_nxt;
  logic signed [15:0]      skid_x_r, skid_y_r, skid_z_r, skid_w_r;
  logic signed [15:0]      pipe_x, pipe_y, pipe_z, pipe_w;
  logic signed [FRACTION_BITS+1:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_XYZ;
    end else if (cfg_valid) begin
      order_r <= cfg_rotation_order;
    end
  end

  assign adv      = !skid_v_r;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  e2q_cordic #(.FRACTION_BITS(FRACTION_BITS)) u_cordic_x (
    .clk      (clk),
    .en       (adv),
    .angle    (in_angle_x),
    .half_sin (sin_x),
    .half_cos (cos_x)
  );

  e2q_cordic #(.FRACTION_BITS(FRACTION_BITS)) u_cordic_y (
    .clk      (clk),
    .en       (adv),
    .angle    (in_angle_y),
    .half_sin (sin_y),
    .half_cos (cos_y)
  );

  e2q_cordic #(.FRACTION_BITS(FRACTION_BITS)) u_cordic_z (
    .clk      (clk),
    .en       (adv),
    .angle    (in_angle_z),
    .half_sin (sin_z),
    .half_cos (cos_z)
  );

  e2q_combine #(.FRACTION_BITS(FRACTION_BITS)) u_combine (
    .clk    (clk),
    .en     (adv),
    .signs  (order_signs(order_r)),
    .s1     (sin_x),
    .c1     (cos_x),
    .s2     (sin_y),
    .c2     (cos_y),
    .s3     (sin_z),
    .c3     (cos_z),
    .quat_x (pipe_x),
    .quat_y (pipe_y),
    .quat_z (pipe_z),
    .quat_w (pipe_w)
  );

  // skid register catches the last stage's item when the consumer stalls
  always_comb begin
    if (skid_v_r) begin
      skid_v_nxt = !out_ready;
    end else begin
      skid_v_nxt = vld_r[PIPE_DEPTH-1] && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else begin
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_x_r <= pipe_x;
      skid_y_r <= pipe_y;
      skid_z_r <= pipe_z;
      skid_w_r <= pipe_w;
    end
  end

  assign out_valid  = skid_v_r || vld_r[PIPE_DEPTH-1];
  assign out_quat_x = skid_v_r ? skid_x_r : pipe_x;
  assign out_quat_y = skid_v_r ? skid_y_r : pipe_y;
  assign out_quat_z = skid_v_r ? skid_z_r : pipe_z;
  assign out_quat_w = skid_v_r ? skid_w_r : pipe_w;

  `E2Q_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && in_ready, vld_r[0])
  `E2Q_ASSERT_NEXT(a_stall_holds, clk, rst_n, skid_v_r, vld_r == $past(vld_r))
  `E2Q_ASSERT_NEXT(a_skid_no_fill, clk, rst_n, !skid_v_r && !(vld_r[PIPE_DEPTH-1] && !out_ready), !skid_v_r)
  `E2Q_ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_v_r && out_ready, !skid_v_r)

endmodule

>>> tb/euler_to_quaternion_checker.sv
// checker for the euler to quaternion converter: predicts each result and compares it
`timescale 1ns / 1ps
module euler_to_quaternion_checker import e2q_pkg::*; #(
  parameter int FRACTION_BITS = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_angle_x,
  input  logic signed [15:0] in_angle_y,
  input  logic signed [15:0] in_angle_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_quat_x,
  input  logic signed [15:0] out_quat_y,
  input  logic signed [15:0] out_quat_z,
  input  logic signed [15:0] out_quat_w,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  order_t             cfg_rotation_order,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } quat_t;

  localparam logic signed [31:0] HALF_ANGLE_STEP [0:CORDIC_STEPS-1] = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
    32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
    32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
    32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
    32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051, 32'sh00000029,
    32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000003, 32'sh00000001
  };

  quat_t  quat_expected_q [$];
  quat_t  want;
  order_t active_order;

  initial fail_count = 0;

  function automatic longint round_to(input longint v, input int s);
    if (s == 0) return v;
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_unit(input longint v);
    longint one;
    one = longint'(1) <<< FRACTION_BITS;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic void half_angle_sin_cos(input logic signed [15:0] a,
                                             output longint s, output longint c);
    longint x, y, z, dx, dy;
    x = longint'(CORDIC_GAIN);
    y = 0;
    z = longint'(a) * 32768;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(HALF_ANGLE_STEP[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(HALF_ANGLE_STEP[i]);
      end
    end
    c = clamp_unit(round_to(x, CORDIC_FRAC - FRACTION_BITS));
    s = clamp_unit(round_to(y, CORDIC_FRAC - FRACTION_BITS));
  endfunction

  // bit 0 x, bit 1 y, bit 2 z, bit 3 w; set means subtract
  function automatic logic [3:0] subtract_mask(input order_t ord);
    case (ord)
      ORDER_XYZ: return 4'b1010;
      ORDER_YXZ: return 4'b0110;
      ORDER_ZXY: return 4'b1001;
      ORDER_ZYX: return 4'b0101;
      ORDER_YZX: return 4'b1100;
      ORDER_XZY: return 4'b0011;
      default:   return 4'b1010;
    endcase
  endfunction

  function automatic longint combine_terms(input longint p1, f1, p2, f2, input logic sub);
    longint t1, t2;
    t1 = p1 * f1;
    t2 = p2 * f2;
    return clamp_unit(round_to(sub ? t1 - t2 : t1 + t2, FRACTION_BITS));
  endfunction

  function automatic quat_t predict_quaternion(input logic signed [15:0] ax, ay, az,
                                               input order_t ord);
    longint s1, c1, s2, c2, s3, c3, sc, cs, cc, ss;
    logic [3:0] neg;
    quat_t q;
    half_angle_sin_cos(ax, s1, c1);
    half_angle_sin_cos(ay, s2, c2);
    half_angle_sin_cos(az, s3, c3);
    neg = subtract_mask(ord);
    sc = round_to(s1 * c2, FRACTION_BITS);
    cs = round_to(c1 * s2, FRACTION_BITS);
    cc = round_to(c1 * c2, FRACTION_BITS);
    ss = round_to(s1 * s2, FRACTION_BITS);
    q.qx = 16'(combine_terms(sc, c3, cs, s3, neg[0]));
    q.qy = 16'(combine_terms(cs, c3, sc, s3, neg[1]));
    q.qz = 16'(combine_terms(cc, s3, ss, c3, neg[2]));
    q.qw = 16'(combine_terms(cc, c3, ss, s3, neg[3]));
    return q;
  endfunction

  task automatic check_field(input string name, input logic signed [15:0] exp_v, act_v);
    if (act_v !== exp_v) begin
      $error("%s expected %0d actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      quat_expected_q.delete();
      active_order = ORDER_XYZ;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_order = cfg_rotation_order;
      end
      if (out_valid && out_ready) begin
        if (quat_expected_q.size() == 0) begin
          $error("result item with no expected item: x %0d y %0d z %0d w %0d",
                 out_quat_x, out_quat_y, out_quat_z, out_quat_w);
          fail_count++;
        end else begin
          want = quat_expected_q.pop_front();
          check_field("quat_x", want.qx, out_quat_x);
          check_field("quat_y", want.qy, out_quat_y);
          check_field("quat_z", want.qz, out_quat_z);
          check_field("quat_w", want.qw, out_quat_w);
        end
      end
      if (in_valid && in_ready) begin
        quat_expected_q.push_back(
          predict_quaternion(in_angle_x, in_angle_y, in_angle_z, active_order));
      end
      pending <= quat_expected_q.size();
    end
  end

endmodule

>>> tb/tb_euler_to_quaternion.sv
// testbench top for the euler to quaternion converter: stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb_euler_to_quaternion import e2q_pkg::*; ();

  localparam int     FRACTION_BITS    = 14;
  localparam order_t ORDER_SPARE_6    = 3'd6;
  localparam order_t ORDER_SPARE_7    = 3'd7;
  localparam int     ITEMS_PER_PHASE  = 160;
  localparam int     CYCLE_LIMIT      = 200000;
  localparam int     DRAIN_CYCLES     = PIPE_DEPTH + 4;
  localparam int     LONG_HOLD_CYCLES = 200;
  localparam order_t ORDER_SWEEP [0:7] = '{
    ORDER_ZYX, ORDER_SPARE_7, ORDER_YXZ, ORDER_ZXY,
    ORDER_SPARE_6, ORDER_YZX, ORDER_XZY, ORDER_XYZ
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_angle_x;
  logic signed [15:0] in_angle_y;
  logic signed [15:0] in_angle_z;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_quat_x;
  logic signed [15:0] out_quat_y;
  logic signed [15:0] out_quat_z;
  logic signed [15:0] out_quat_w;
  logic               cfg_valid;
  logic               cfg_ready;
  order_t             cfg_rotation_order;

  int   fail_count;
  int   pending;
  int   cycle_count;
  int   send_idle_pct;
  int   recv_stall_pct;
  logic long_hold_req;

  euler_to_quaternion #(.FRACTION_BITS(FRACTION_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_angle_x(in_angle_x), .in_angle_y(in_angle_y), .in_angle_z(in_angle_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_quat_x(out_quat_x), .out_quat_y(out_quat_y),
    .out_quat_z(out_quat_z), .out_quat_w(out_quat_w),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_rotation_order(cfg_rotation_order)
  );

  euler_to_quaternion_checker #(.FRACTION_BITS(FRACTION_BITS)) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_angle_x(in_angle_x), .in_angle_y(in_angle_y), .in_angle_z(in_angle_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_quat_x(out_quat_x), .out_quat_y(out_quat_y),
    .out_quat_z(out_quat_z), .out_quat_w(out_quat_w),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_rotation_order(cfg_rotation_order),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("euler_to_quaternion verification failed");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_angles(input logic signed [15:0] ax, ay, az);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_angle_x <= ax;
    in_angle_y <= ay;
    in_angle_z <= az;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_order(input order_t ord);
    cfg_valid          <= 1'b1;
    cfg_rotation_order <= ord;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [15:0] random_angle();
    case ($urandom_range(15))
      0: begin
        case ($urandom_range(6))
          0: return 16'sh8000;
          1: return 16'sd32767;
          2: return 16'sd0;
          3: return 16'sd16384;
          4: return -16'sd16384;
          5: return 16'sd1;
          default: return -16'sd1;
        endcase
      end
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  initial begin : stimulus
    int p;
    int n;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_angle_x         = '0;
    in_angle_y         = '0;
    in_angle_z         = '0;
    cfg_valid          = 1'b0;
    cfg_rotation_order = ORDER_XYZ;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    long_hold_req      = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset order, field extremes and quarter turns
    send_angles(16'sd0, 16'sd0, 16'sd0);
    send_angles(16'sh8000, 16'sh8000, 16'sh8000);
    send_angles(16'sd32767, 16'sd32767, 16'sd32767);
    send_angles(16'sh8000, 16'sd0, 16'sd0);
    send_angles(16'sd0, 16'sh8000, 16'sd0);
    send_angles(16'sd0, 16'sd0, 16'sh8000);
    send_angles(16'sd32767, 16'sh8000, 16'sd0);
    send_angles(16'sd16384, 16'sd16384, 16'sd16384);
    send_angles(-16'sd16384, 16'sd16384, -16'sd16384);
    send_angles(16'sd8192, -16'sd8192, 16'sd24576);
    send_angles(16'sd1, -16'sd1, 16'sd1);
    send_angles(-16'sd1, 16'sd0, 16'sd32767);
    send_angles(16'sd21845, -16'sd21845, 16'sd10923);
    in_valid <= 1'b0;

    for (p = 0; p < 8; p++) begin
      wait_drained();
      write_order(ORDER_SWEEP[p]);
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 63;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 63;
        end
        default: begin
          send_idle_pct  = 18;
          recv_stall_pct = 18;
        end
      endcase
      if (p == 0) long_hold_req = 1'b1;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_angles(random_angle(), random_angle(), random_angle());
      end
      in_valid <= 1'b0;
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("euler_to_quaternion verification clean");
    end else begin
      $display("euler_to_quaternion verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/e2q_pkg.sv
rtl/e2q_cordic.sv
rtl/e2q_combine.sv
rtl/euler_to_quaternion.sv
tb/euler_to_quaternion_checker.sv
tb/tb_euler_to_quaternion.sv
